// ===== sv/clause_status_evaluator_macros.svh =====
`ifndef CLAUSE_STATUS_EVALUATOR_MACROS_SVH
`define CLAUSE_STATUS_EVALUATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define CES_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clause_status_evaluator check failed");

// next-cycle implication, checked outside reset
`define CES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clause_status_evaluator check failed");

`endif

// ===== sv/ces_pkg.sv =====
package ces_pkg;

    localparam int ATOM_COUNT     = 1024;
    localparam int MAX_CLAUSE_LEN = 256;

    localparam int ATOM_W   = 10;
    localparam int LIT_W    = 11;
    localparam int VAL_W    = 2;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;
    localparam int ATOM_AW  = $clog2(ATOM_COUNT);

    localparam int POS_TOP_INT = ((MAX_CLAUSE_LEN - 1) < 255) ? (MAX_CLAUSE_LEN - 1) : 255;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(POS_TOP_INT);

    localparam logic [VAL_W-1:0] VAL_FALSE = 2'd0;
    localparam logic [VAL_W-1:0] VAL_TRUE  = 2'd1;
    localparam logic [VAL_W-1:0] VAL_NONE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_SATISFIED = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNIT      = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDECIDED = 2'd2;
    localparam logic [STAT_W-1:0] ST_CONTRA    = 2'd3;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_EVAL   = 1'b1;

    typedef struct packed {
        logic               wr_en;
        logic [ATOM_AW-1:0] wr_addr;
        logic [VAL_W-1:0]   wr_data;
        logic               rd_en;
        logic [ATOM_AW-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [ATOM_W-1:0] atom;
        logic              neg;
        logic              in_range;
        logic              last;
    } t_lit_issue;

endpackage

// ===== sv/ces_model_mem.sv =====
module ces_model_mem
    import ces_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_req         i_req,
    output logic [VAL_W-1:0] o_rd_data,
    output logic             o_clearing
);

    logic [VAL_W-1:0]   mem [ATOM_COUNT];
    logic [VAL_W-1:0]   r_rd_data;
    logic               r_clearing;
    logic [ATOM_AW-1:0] r_clr_addr;

    logic               wr_en;
    logic [ATOM_AW-1:0] wr_addr;
    logic [VAL_W-1:0]   wr_data;

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = VAL_NONE;
        end else begin
            wr_en   = i_req.wr_en;
            wr_addr = i_req.wr_addr;
            wr_data = i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ATOM_AW'(ATOM_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ===== sv/ces_clause_eval.sv =====
`include "clause_status_evaluator_macros.svh"

module ces_clause_eval
    import ces_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lit_issue        i_issue,
    input  logic [VAL_W-1:0]  i_rd_data,
    output logic              o_can_take,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_clause_status,
    output logic [POS_W-1:0]  o_unit_position
);

    logic              r_s1_valid;
    logic [ATOM_W-1:0] r_s1_atom;
    logic              r_s1_neg;
    logic              r_s1_in_range;
    logic              r_s1_last;

    logic              r_none_seen, n_none_seen;
    logic [ATOM_W-1:0] r_none_atom, n_none_atom;
    logic [POS_W-1:0]  r_none_pos, n_none_pos;
    logic              r_decided, n_decided;
    logic [STAT_W-1:0] r_dec_status, n_dec_status;
    logic [POS_W-1:0]  r_lit_pos, n_lit_pos;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;

    logic              out_free;
    logic              s1_adv;
    logic [VAL_W-1:0]  val;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!r_s1_last || out_free);
    assign o_can_take = !r_s1_valid || s1_adv;
    assign val        = r_s1_in_range ? i_rd_data : VAL_NONE;

    always_comb begin
        n_none_seen  = r_none_seen;
        n_none_atom  = r_none_atom;
        n_none_pos   = r_none_pos;
        n_decided    = r_decided;
        n_dec_status = r_dec_status;
        n_lit_pos    = r_lit_pos;
        n_out_status = ST_CONTRA;
        n_out_pos    = '0;

        if (!r_decided) begin
            if (val == VAL_NONE) begin
                if (r_none_seen && (r_s1_atom != r_none_atom)) begin
                    n_decided    = 1'b1;
                    n_dec_status = ST_UNDECIDED;
                end else begin
                    n_none_seen = 1'b1;
                    n_none_atom = r_s1_atom;
                    n_none_pos  = r_lit_pos;
                end
            end else if (val[0] != r_s1_neg) begin
                n_decided    = 1'b1;
                n_dec_status = ST_SATISFIED;
            end
        end

        if (n_decided) begin
            n_out_status = n_dec_status;
            n_out_pos    = (n_dec_status == ST_UNDECIDED) ? n_none_pos : '0;
        end else if (n_none_seen) begin
            n_out_status = ST_UNIT;
            n_out_pos    = n_none_pos;
        end

        if (!r_s1_last) begin
            if (r_lit_pos < POS_TOP) begin
                n_lit_pos = r_lit_pos + 1'b1;
            end
        end else begin
            n_none_seen  = 1'b0;
            n_none_atom  = '0;
            n_none_pos   = '0;
            n_decided    = 1'b0;
            n_dec_status = ST_SATISFIED;
            n_lit_pos    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_none_seen  <= 1'b0;
            r_none_atom  <= '0;
            r_none_pos   <= '0;
            r_decided    <= 1'b0;
            r_dec_status <= ST_SATISFIED;
            r_lit_pos    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_can_take) begin
                r_s1_valid <= i_issue.valid;
            end
            if (s1_adv) begin
                r_none_seen  <= n_none_seen;
                r_none_atom  <= n_none_atom;
                r_none_pos   <= n_none_pos;
                r_decided    <= n_decided;
                r_dec_status <= n_dec_status;
                r_lit_pos    <= n_lit_pos;
            end
            if (s1_adv && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_issue.valid) begin
            r_s1_atom     <= i_issue.atom;
            r_s1_neg      <= i_issue.neg;
            r_s1_in_range <= i_issue.in_range;
            r_s1_last     <= i_issue.last;
        end
        if (s1_adv && r_s1_last) begin
            r_out_status <= n_out_status;
            r_out_pos    <= n_out_pos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clause_status = r_out_status;
    assign o_unit_position = r_out_pos;

    `CES_ASSERT_NOW(a_zero_pos, r_out_valid && (r_out_status == ST_SATISFIED || r_out_status == ST_CONTRA), r_out_pos == '0)
    `CES_ASSERT_NEXT(a_clause_cleared, s1_adv && r_s1_last, !r_decided && !r_none_seen && r_lit_pos == '0)
    `CES_ASSERT_NOW(a_pos_bound, r_none_seen, r_none_pos <= r_lit_pos && r_lit_pos <= POS_TOP)

endmodule

// ===== sv/clause_status_evaluator.sv =====
// Clause status evaluator.
// Request channel (i_in_valid / o_in_ready): func 0 writes assign_value into the
// model entry of atom_index; func 1 presents one literal of a clause, with
// last_literal marking the final one. Only a final literal yields a result.
// Result channel (o_out_valid / i_out_ready): clause_status and unit_position.
// Path: the final literal and its model read are registered in the evaluation
// stage, and its result then in the output register that drives o_out_valid.
// Throughput: one request per cycle while o_in_ready is high, assigns and
// literals freely mixed; each literal is one read of the model memory and one
// registered evaluation step. Reset: a clearing pass writes all 1024 model
// entries to unassigned, one entry a cycle, with o_in_ready low until it ends.
// Stall: a waiting result holds in the output register while literals that are
// not final keep flowing; a final literal holds in the evaluation stage until
// the output register frees, and o_in_ready then drops.
module clause_status_evaluator
    import ces_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [ATOM_W-1:0] i_atom_index,
    input  logic [VAL_W-1:0]  i_assign_value,
    input  logic [LIT_W-1:0]  i_literal,
    input  logic              i_last_literal,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_clause_status,
    output logic [POS_W-1:0]  o_unit_position
);

    t_mem_req          mem_req;
    t_lit_issue        issue;
    logic [VAL_W-1:0]  rd_data;
    logic              clearing;
    logic              can_take;
    logic              accept;
    logic [ATOM_W-1:0] lit_atom;

    assign o_in_ready = !clearing && can_take;
    assign accept     = i_in_valid && o_in_ready;
    assign lit_atom   = i_literal[LIT_W-1:1];

    always_comb begin
        mem_req.wr_en   = accept && (i_func == FUNC_ASSIGN)
                          && (32'(i_atom_index) < ATOM_COUNT);
        mem_req.wr_addr = i_atom_index[ATOM_AW-1:0];
        mem_req.wr_data = (i_assign_value > VAL_TRUE) ? VAL_NONE : i_assign_value;
        mem_req.rd_en   = accept && (i_func == FUNC_EVAL);
        mem_req.rd_addr = lit_atom[ATOM_AW-1:0];

        issue.valid    = accept && (i_func == FUNC_EVAL);
        issue.atom     = lit_atom;
        issue.neg      = i_literal[0];
        issue.in_range = 32'(lit_atom) < ATOM_COUNT;
        issue.last     = i_last_literal;
    end

    ces_model_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    ces_clause_eval u_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_issue         (issue),
        .i_rd_data       (rd_data),
        .o_can_take      (can_take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_clause_status (o_clause_status),
        .o_unit_position (o_unit_position)
    );

endmodule
